[design/ctvp_pkg.sv]
// Shared types and constants of the constant-velocity track predictor.
package ctvp_pkg;

  // Object table
  localparam int MAX_OBJECTS = 16;
  localparam int OBJ_ID_W    = 4;
  localparam int OBJ_SLOTS   = 2 ** OBJ_ID_W;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // Shared divider: two quotient bits per cycle over a 32-bit dividend
  localparam int DIV_CYCLES  = 16;
  localparam int DIV_CNT_W   = 4;

  // Item classes decided by the front
  localparam logic [1:0] CLS_SINGLE = 2'd0;
  localparam logic [1:0] CLS_EQUAL  = 2'd1;
  localparam logic [1:0] CLS_FIT    = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_SINGLE = 2'd1;
  localparam logic [1:0] ST_EQUAL  = 2'd2;
  localparam logic [1:0] ST_SAT    = 2'd3;

  // One classified item, as handed from front to back
  typedef struct packed {
    logic [OBJ_ID_W-1:0] obj;
    logic [1:0]          cls;
    logic [2:0][31:0]    q1;   // older point, per axis
    logic [2:0][31:0]    q2;   // newest point, per axis
    logic [31:0]         t1;
    logic [31:0]         t2;
  } cmd_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[design/ctvp_front.sv]
// Front end: accepts samples, applies the skip counter, keeps per-object points, classifies.
module ctvp_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [7:0]                    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ctvp_pkg::OBJ_ID_W-1:0] in_object_id,
  input  logic signed [31:0]            in_pos_x,
  input  logic signed [31:0]            in_pos_y,
  input  logic signed [31:0]            in_pos_z,
  input  logic [31:0]                   in_time_stamp,
  input  ctvp_pkg::q_status_t           q_status,
  output logic                          push,
  output ctvp_pkg::cmd_t                push_cmd
);

  logic [7:0]  skip_count_r, skip_count_nxt;
  logic [7:0]  skip_cnt_r [ctvp_pkg::OBJ_SLOTS];
  logic [ctvp_pkg::OBJ_SLOTS-1:0] seen_r, seen_nxt;
  logic [2:0][31:0] newest_pos_r [ctvp_pkg::OBJ_SLOTS];
  logic [31:0] newest_time_r [ctvp_pkg::OBJ_SLOTS];

  logic        accept;
  logic        in_range;
  logic [7:0]  cnt_inc;
  logic        keep;
  logic        had_point;
  logic [31:0] old_time;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  assign in_range = ({1'b0, in_object_id} < (ctvp_pkg::OBJ_ID_W + 1)'(ctvp_pkg::MAX_OBJECTS));

  // Skip counter: keep the sample once the count reaches skip_count (0 acts as 1)
  assign cnt_inc   = skip_cnt_r[in_object_id] + 8'd1;
  assign keep      = in_range && !(cnt_inc < skip_count_r);
  assign had_point = seen_r[in_object_id];
  assign old_time  = newest_time_r[in_object_id];

  assign push = accept && keep;

  // Classify and build the command for the back end
  always_comb begin
    push_cmd       = '0;
    push_cmd.obj   = in_object_id;
    push_cmd.q1    = newest_pos_r[in_object_id];
    push_cmd.q2    = {in_pos_z, in_pos_y, in_pos_x};
    push_cmd.t2    = in_time_stamp;
    if (!had_point) begin
      push_cmd.cls = ctvp_pkg::CLS_SINGLE;
      push_cmd.t1  = in_time_stamp;
    end else if (old_time == in_time_stamp) begin
      push_cmd.cls = ctvp_pkg::CLS_EQUAL;
      push_cmd.t1  = old_time;
    end else begin
      push_cmd.cls = ctvp_pkg::CLS_FIT;
      push_cmd.t1  = old_time;
    end
  end

  // Configuration register
  always_comb begin
    skip_count_nxt = skip_count_r;
    if (cfg_valid) begin
      skip_count_nxt = cfg_data;
    end
  end

  // Point count: one bit per object, set by its first kept sample
  always_comb begin
    seen_nxt = seen_r;
    if (push) begin
      seen_nxt[in_object_id] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_count_r <= 8'd1;
      seen_r       <= '0;
    end else begin
      skip_count_r <= skip_count_nxt;
      seen_r       <= seen_nxt;
    end
  end

  // Per-object skip counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ctvp_pkg::OBJ_SLOTS; i++) begin
        skip_cnt_r[i] <= 8'd0;
      end
    end else if (accept && in_range) begin
      skip_cnt_r[in_object_id] <= keep ? 8'd0 : cnt_inc;
    end
  end

  // Newest point per object; used only once the object has a point
  always_ff @(posedge clk) begin
    if (push) begin
      newest_pos_r[in_object_id]  <= {in_pos_z, in_pos_y, in_pos_x};
      newest_time_r[in_object_id] <= in_time_stamp;
    end
  end

endmodule

[design/ctvp_queue.sv]
// Two-entry command queue between the front and back ends.
module ctvp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ctvp_pkg::cmd_t      push_cmd,
  input  logic                pop,
  output ctvp_pkg::cmd_t      head,
  output ctvp_pkg::q_status_t status
);

  ctvp_pkg::cmd_t mem_r [ctvp_pkg::QUEUE_DEPTH];
  logic [ctvp_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [ctvp_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [ctvp_pkg::QCNT_W-1:0] count_r, count_nxt;
  logic do_push, do_pop;

  assign status.full  = (count_r == ctvp_pkg::QCNT_W'(ctvp_pkg::QUEUE_DEPTH));
  assign status.empty = (count_r == '0);
  assign head         = mem_r[rd_ptr_r];

  assign do_push = push && !status.full;
  assign do_pop  = pop && !status.empty;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[design/ctvp_back.sv]
// Back end: per-axis rate by a shared radix-4 divider, offset by one multiply, result register.
module ctvp_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ctvp_pkg::cmd_t                head,
  input  ctvp_pkg::q_status_t           q_status,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ctvp_pkg::OBJ_ID_W-1:0] out_object_out,
  output logic signed [31:0]            out_offset_x,
  output logic signed [31:0]            out_offset_y,
  output logic signed [31:0]            out_offset_z,
  output logic signed [31:0]            out_rate_x,
  output logic signed [31:0]            out_rate_y,
  output logic signed [31:0]            out_rate_z,
  output logic [31:0]                   out_span_start,
  output logic [31:0]                   out_span_end,
  output logic [1:0]                    out_fit_status
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_LOAD = 3'd1;
  localparam logic [2:0] B_DIV  = 3'd2;
  localparam logic [2:0] B_RATE = 3'd3;
  localparam logic [2:0] B_MUL  = 3'd4;
  localparam logic [2:0] B_OFF  = 3'd5;
  localparam logic [2:0] B_DONE = 3'd6;

  localparam logic [1:0] LAST_AXIS = 2'd2;

  logic [2:0]  state_r, state_nxt;
  logic [1:0]  axis_r, axis_nxt;
  ctvp_pkg::cmd_t cur_r, cur_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic        neg_r, neg_nxt;
  logic [ctvp_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic        sat_r, sat_nxt;
  logic [2:0][31:0] rate_r, rate_nxt;
  logic [2:0][31:0] off_r, off_nxt;
  logic signed [64:0] prod_r, prod_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [ctvp_pkg::OBJ_ID_W-1:0] o_obj_r;
  logic [2:0][31:0] o_off_r, o_rate_r;
  logic [31:0] o_t1_r, o_t2_r;
  logic [1:0]  o_status_r;
  logic        load_out;
  logic [1:0]  status;

  logic signed [32:0] diff, dt;
  logic [32:0] s1, s2;
  logic signed [65:0] off_full;

  // One restoring step: {remainder, quotient bit}
  function automatic logic [32:0] div_step(input logic [31:0] rem, input logic nb,
                                           input logic [31:0] d);
    logic [32:0] part;
    logic [32:0] trial;
    begin
      part  = {rem, nb};
      trial = part - {1'b0, d};
      if (part >= {1'b0, d}) begin
        div_step = {trial[31:0], 1'b1};
      end else begin
        div_step = {part[31:0], 1'b0};
      end
    end
  endfunction

  // Axis operands; span and difference fit in 33 bits signed
  assign diff = $signed({cur_r.q2[axis_r][31], cur_r.q2[axis_r]})
              - $signed({cur_r.q1[axis_r][31], cur_r.q1[axis_r]});
  assign dt   = $signed({1'b0, cur_r.t2}) - $signed({1'b0, cur_r.t1});

  // Two quotient bits per cycle
  assign s1 = div_step(rem_r, quo_r[31], dvs_r);
  assign s2 = div_step(s1[32:1], quo_r[30], dvs_r);

  // Offset before clamping
  assign off_full = $signed({{34{cur_r.q1[axis_r][31]}}, cur_r.q1[axis_r]})
                  - $signed({prod_r[64], prod_r});

  assign pop      = (state_r == B_IDLE) && !q_status.empty;
  assign load_out = (state_r == B_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    case (cur_r.cls)
      ctvp_pkg::CLS_SINGLE: status = ctvp_pkg::ST_SINGLE;
      ctvp_pkg::CLS_EQUAL:  status = ctvp_pkg::ST_EQUAL;
      default:              status = sat_r ? ctvp_pkg::ST_SAT : ctvp_pkg::ST_OK;
    endcase
  end

  // Sequencer over the three axes
  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    cur_nxt   = cur_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    dvs_nxt   = dvs_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    sat_nxt   = sat_r;
    rate_nxt  = rate_r;
    off_nxt   = off_r;
    prod_nxt  = prod_r;
    case (state_r)
      B_IDLE: begin
        if (pop) begin
          cur_nxt  = head;
          axis_nxt = 2'd0;
          sat_nxt  = 1'b0;
          rate_nxt = '0;
          off_nxt  = head.q2;
          state_nxt = (head.cls == ctvp_pkg::CLS_FIT) ? B_LOAD : B_DONE;
        end
      end
      B_LOAD: begin
        quo_nxt   = diff[32] ? 32'(-diff) : diff[31:0];
        dvs_nxt   = dt[32] ? 32'(-dt) : dt[31:0];
        neg_nxt   = diff[32] ^ dt[32];
        rem_nxt   = '0;
        cnt_nxt   = ctvp_pkg::DIV_CNT_W'(ctvp_pkg::DIV_CYCLES - 1);
        state_nxt = B_DIV;
      end
      B_DIV: begin
        rem_nxt = s2[32:1];
        quo_nxt = {quo_r[29:0], s1[0], s2[0]};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = B_RATE;
        end
      end
      B_RATE: begin
        // Sign and clamp the quotient magnitude
        if (neg_r) begin
          if (quo_r > 32'h8000_0000) begin
            rate_nxt[axis_r] = 32'h8000_0000;
            sat_nxt          = 1'b1;
          end else begin
            rate_nxt[axis_r] = -quo_r;
          end
        end else if (quo_r[31]) begin
          rate_nxt[axis_r] = 32'h7fff_ffff;
          sat_nxt          = 1'b1;
        end else begin
          rate_nxt[axis_r] = quo_r;
        end
        state_nxt = B_MUL;
      end
      B_MUL: begin
        prod_nxt  = $signed(rate_r[axis_r]) * $signed({1'b0, cur_r.t1});
        state_nxt = B_OFF;
      end
      B_OFF: begin
        // Clamp the offset to signed 32 bits
        if ((&off_full[65:31]) || !(|off_full[65:31])) begin
          off_nxt[axis_r] = off_full[31:0];
        end else begin
          off_nxt[axis_r] = off_full[65] ? 32'h8000_0000 : 32'h7fff_ffff;
          sat_nxt         = 1'b1;
        end
        if (axis_r == LAST_AXIS) begin
          state_nxt = B_DONE;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = B_LOAD;
        end
      end
      B_DONE: begin
        if (load_out) begin
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  // Result register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    axis_r <= axis_nxt;
    cur_r  <= cur_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dvs_r  <= dvs_nxt;
    neg_r  <= neg_nxt;
    cnt_r  <= cnt_nxt;
    sat_r  <= sat_nxt;
    rate_r <= rate_nxt;
    off_r  <= off_nxt;
    prod_r <= prod_nxt;
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      o_obj_r    <= cur_r.obj;
      o_off_r    <= off_r;
      o_rate_r   <= rate_r;
      o_t1_r     <= cur_r.t1;
      o_t2_r     <= cur_r.t2;
      o_status_r <= status;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_object_out = o_obj_r;
  assign out_offset_x   = o_off_r[0];
  assign out_offset_y   = o_off_r[1];
  assign out_offset_z   = o_off_r[2];
  assign out_rate_x     = o_rate_r[0];
  assign out_rate_y     = o_rate_r[1];
  assign out_rate_z     = o_rate_r[2];
  assign out_span_start = o_t1_r;
  assign out_span_end   = o_t2_r;
  assign out_fit_status = o_status_r;

endmodule

[design/const_velocity_track_predictor.sv]
// Top level of the two-point constant-velocity track predictor.
//
//   channel   direction  handshake              payload
//   cfg       in         cfg_valid / cfg_ready  cfg_data (skip_count)
//   in        in         in_valid / in_ready    object id, x/y/z position, time stamp
//   out       out        out_valid / out_ready  object, offsets, rates, span, status
//
// A two-point fit holds the back end through, per axis, a load, the divider steps at
// two quotient bits each, then clamp, multiply and offset; plus pop and done. A single
// point or equal times go from pop straight to done. The front takes a sample whenever
// the two-entry queue has room; dropped samples never reach the queue.
// Reset clears the skip counters and point flags of all objects at once; no sweep.
// A stalled result holds in the output register while the back end waits.
module const_velocity_track_predictor (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [7:0]                    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ctvp_pkg::OBJ_ID_W-1:0] in_object_id,
  input  logic signed [31:0]            in_pos_x,
  input  logic signed [31:0]            in_pos_y,
  input  logic signed [31:0]            in_pos_z,
  input  logic [31:0]                   in_time_stamp,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ctvp_pkg::OBJ_ID_W-1:0] out_object_out,
  output logic signed [31:0]            out_offset_x,
  output logic signed [31:0]            out_offset_y,
  output logic signed [31:0]            out_offset_z,
  output logic signed [31:0]            out_rate_x,
  output logic signed [31:0]            out_rate_y,
  output logic signed [31:0]            out_rate_z,
  output logic [31:0]                   out_span_start,
  output logic [31:0]                   out_span_end,
  output logic [1:0]                    out_fit_status
);

  logic                push;
  logic                pop;
  ctvp_pkg::cmd_t      push_cmd;
  ctvp_pkg::cmd_t      head;
  ctvp_pkg::q_status_t q_status;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  ctvp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_object_id  (in_object_id),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_pos_z      (in_pos_z),
    .in_time_stamp (in_time_stamp),
    .q_status      (q_status),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  ctvp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  ctvp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .q_status       (q_status),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_object_out (out_object_out),
    .out_offset_x   (out_offset_x),
    .out_offset_y   (out_offset_y),
    .out_offset_z   (out_offset_z),
    .out_rate_x     (out_rate_x),
    .out_rate_y     (out_rate_y),
    .out_rate_z     (out_rate_z),
    .out_span_start (out_span_start),
    .out_span_end   (out_span_end),
    .out_fit_status (out_fit_status)
  );

endmodule

[design/ctvp_checker.sv]
// Port-level checks of the track predictor, bound to the top level.
module ctvp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ctvp_pkg::OBJ_ID_W-1:0] out_object_out,
  input logic signed [31:0]            out_offset_x,
  input logic signed [31:0]            out_rate_x,
  input logic signed [31:0]            out_rate_y,
  input logic signed [31:0]            out_rate_z,
  input logic [31:0]                   out_span_start,
  input logic [31:0]                   out_span_end,
  input logic [1:0]                    out_fit_status
);

  // A stalled result stays put (valid, object, x offset and x rate are checked)
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_object_out)
      && $stable(out_offset_x) && $stable(out_rate_x))
    else $error("result changed while stalled");

  // Single point: zero rate, span collapsed to one time
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fit_status == ctvp_pkg::ST_SINGLE |->
      out_rate_x == 0 && out_rate_y == 0 && out_rate_z == 0
      && out_span_start == out_span_end)
    else $error("single-point result malformed");

  // Equal times: zero rate, span collapsed to one time
  a_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fit_status == ctvp_pkg::ST_EQUAL |->
      out_rate_x == 0 && out_rate_y == 0 && out_rate_z == 0
      && out_span_start == out_span_end)
    else $error("equal-time result malformed");

  // A clean fit always spans two distinct times
  a_fit_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fit_status == ctvp_pkg::ST_OK |-> out_span_start != out_span_end)
    else $error("fit over an empty span");

  // No result right after a reset cycle
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind const_velocity_track_predictor ctvp_checker u_ctvp_checker (.*);
